FILE: hdl/dlsum_pkg.sv
// Shared types and constants for the delimited decimal list summer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dlsum_pkg;

    // Largest number of values a line may carry
    localparam int MAX_VALUES = 10;
    localparam int CNT_W      = $clog2(MAX_VALUES + 1);

    // Magnitude limit: a negative value may reach this, a positive one limit minus one
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [2:0] {
        PH_EMPTY  = 3'd0,
        PH_LEAD   = 3'd1,
        PH_SIGN   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_TRAIL  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_NUMERIC = 3'd1,
        ST_RANGE       = 3'd2,
        ST_NONE        = 3'd3,
        ST_TOO_MANY    = 3'd4
    } t_status;

    // One character transaction as held in the input register
    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } t_char_item;

    // End-of-line summary
    typedef struct packed {
        t_status     status;
        logic [31:0] total;
        logic [3:0]  value_count;
    } t_result;

    // Per-line scanner state
    typedef struct packed {
        t_phase           phase;
        logic             neg;
        logic [31:0]      mag;
        logic             too_big;
        logic [31:0]      total;
        logic [CNT_W-1:0] count;
        t_status          err;
        logic             ended;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        phase:   PH_EMPTY,
        neg:     1'b0,
        mag:     32'd0,
        too_big: 1'b0,
        total:   32'd0,
        count:   '0,
        err:     ST_OK,
        ended:   1'b0
    };

endpackage

`default_nettype wire

FILE: hdl/dlsum_in_stage.sv
// Input register for character transactions, with upstream ready.
// Depends on dlsum_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlsum_in_stage
    import dlsum_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_line_end,
    input  wire logic       i_out_free,
    output t_char_item      o_item,
    output logic            o_fire
);

    logic       r_valid;
    t_char_item r_item;

    // Advance unless a line end would meet a full result register
    assign o_fire  = r_valid && (!r_item.line_end || i_out_free);
    assign o_ready = !r_valid || o_fire;
    assign o_item  = r_item;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the payload on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.char_code <= i_char_code;
            r_item.line_end  <= i_line_end;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dlsum_scan.sv
// Token scanner: phase, magnitude accumulate, running sum and error latch.
// Depends on dlsum_pkg. Produces the line summary on the line end character.
`timescale 1ns / 1ps
`default_nettype none

module dlsum_scan
    import dlsum_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire t_char_item i_item,
    output t_result         o_result
);

    t_scan_state r_state;
    t_scan_state n_state;
    t_scan_state s;
    logic        do_fin;
    logic        is_digit;
    logic        is_blank;
    logic        is_sign;
    logic        range_err;
    logic [7:0]  digit;
    logic [34:0] prod;
    logic [31:0] value;

    // Classify the character
    assign is_digit = (i_item.char_code >= CH_ZERO) && (i_item.char_code <= CH_NINE);
    assign is_blank = (i_item.char_code == CH_SPACE) ||
                      ((i_item.char_code >= CH_TAB) && (i_item.char_code <= CH_CR));
    assign is_sign  = (i_item.char_code == CH_PLUS) || (i_item.char_code == CH_MINUS);
    assign digit    = i_item.char_code - CH_ZERO;

    // Magnitude times ten plus digit, as two shifted adds
    assign prod = {r_state.mag, 3'b000} + {2'b00, r_state.mag, 1'b0} + {27'd0, digit};

    always_comb begin
        s         = r_state;
        do_fin    = 1'b0;
        range_err = 1'b0;
        value     = 32'd0;

        // Apply the character unless the line is already settled
        if (!r_state.ended && (r_state.err == ST_OK)) begin
            if (i_item.char_code == CH_NUL) begin
                do_fin  = 1'b1;
                s.ended = 1'b1;
            end else if (i_item.char_code == CH_SEMI) begin
                do_fin = 1'b1;
            end else if (is_digit) begin
                if (r_state.phase == PH_TRAIL) begin
                    s.err = ST_NOT_NUMERIC;
                end else begin
                    if (prod > {3'b000, MAG_LIMIT}) begin
                        s.too_big = 1'b1;
                        s.mag     = MAG_LIMIT;
                    end else begin
                        s.mag = prod[31:0];
                    end
                    s.phase = PH_DIGITS;
                end
            end else if (is_blank) begin
                case (r_state.phase)
                    PH_EMPTY:  s.phase = PH_LEAD;
                    PH_DIGITS: s.phase = PH_TRAIL;
                    PH_SIGN:   s.err   = ST_NOT_NUMERIC;
                    default:   ;
                endcase
            end else if (is_sign &&
                         ((r_state.phase == PH_EMPTY) || (r_state.phase == PH_LEAD))) begin
                s.neg   = (i_item.char_code == CH_MINUS);
                s.phase = PH_SIGN;
            end else begin
                s.err = ST_NOT_NUMERIC;
            end
        end

        // Close the token on a delimiter, a code zero or the line end
        if (do_fin || i_item.line_end) begin
            range_err = s.too_big || (!s.neg && s.mag[31]);
            value     = s.neg ? (32'd0 - s.mag) : s.mag;
            if (s.err == ST_OK) begin
                case (s.phase) inside
                    PH_EMPTY: ;
                    PH_SIGN:  s.err = ST_NOT_NUMERIC;
                    PH_LEAD, PH_DIGITS, PH_TRAIL: begin
                        if ((s.phase != PH_LEAD) && range_err) begin
                            s.err = ST_RANGE;
                        end else if (s.count >= CNT_W'(MAX_VALUES)) begin
                            s.err = ST_TOO_MANY;
                        end else begin
                            s.count = s.count + CNT_W'(1);
                            s.total = s.total + ((s.phase == PH_LEAD) ? 32'd0 : value);
                        end
                    end
                    default: ;
                endcase
            end
            s.phase   = PH_EMPTY;
            s.neg     = 1'b0;
            s.mag     = 32'd0;
            s.too_big = 1'b0;
        end

        // Summarise the line
        if (s.err != ST_OK) begin
            o_result.status = s.err;
            o_result.total  = 32'd0;
        end else if (s.count == '0) begin
            o_result.status = ST_NONE;
            o_result.total  = 32'd0;
        end else begin
            o_result.status = ST_OK;
            o_result.total  = s.total;
        end
        o_result.value_count = 4'(s.count);

        // Advance on each transaction; drop all state after a line end
        if (!i_fire) begin
            n_state = r_state;
        end else if (i_item.line_end) begin
            n_state = SCAN_RESET;
        end else begin
            n_state = s;
        end
    end

    // Hold the scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_RESET;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/delimited_decimal_list_summer_core.sv
// Top level of the delimited decimal list summer: input register, token
// scanner and result register. Depends on dlsum_pkg, dlsum_in_stage, dlsum_scan.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+-------------------------------------------
//   input    | i_valid / o_ready  | i_char_code[7:0], i_line_end
//   result   | o_valid / i_ready  | o_status[2:0], o_total[31:0], o_value_count[3:0]
//
// One character per cycle unless a line end waits on a stalled result: each
// transaction passes the input register, then the scanner updates its state as it leaves.
// A result is registered as its line end character leaves the input register.
// Synchronous active-low reset clears all scanner and handshake state.
// A stalled result holds the next line end in the input register; characters
// before it still flow.
`timescale 1ns / 1ps
`default_nettype none

module delimited_decimal_list_summer_core
    import dlsum_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_line_end,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [31:0]      o_total,
    output logic [3:0]       o_value_count
);

    logic       w_fire;
    logic       w_out_free;
    logic       w_load;
    t_char_item w_item;
    t_result    w_result;
    logic       r_out_valid;
    t_result    r_result;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_load     = w_fire && w_item.line_end;

    dlsum_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_line_end  (i_line_end),
        .i_out_free  (w_out_free),
        .o_item      (w_item),
        .o_fire      (w_fire)
    );

    dlsum_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_item),
        .o_result (w_result)
    );

    // Hold the result valid flag until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the line summary
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_result.status;
    assign o_total       = r_result.total;
    assign o_value_count = r_result.value_count;

    // A new result only follows a line end character leaving the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> $past(w_fire && w_item.line_end))
        else $error("result appeared without a line end");

    // A line end never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || i_ready))
        else $error("pending result overwritten");

    // Any failure status carries a zero total
    a_error_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_total == 32'd0))
        else $error("nonzero total with failure status");

    // The count never passes the value limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_value_count) <= 32'(MAX_VALUES)))
        else $error("value count beyond limit");

endmodule

`default_nettype wire
